/* rtl/core/cbm_pkg.sv */
// Shared types, codes and helpers for the cartridge bank mapper.
package cbm_pkg;

    typedef enum logic [1:0] {
        OP_CART_RD = 2'd0,
        OP_CART_WR = 2'd1,
        OP_REG_RD  = 2'd2,
        OP_REG_WR  = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        TGT_OPEN  = 3'd0,
        TGT_ROM   = 3'd1,
        TGT_PSRAM = 3'd2,
        TGT_PACK  = 3'd3,
        TGT_REG   = 3'd4,
        TGT_RAM   = 3'd5,
        TGT_NONE  = 3'd6
    } t_target;

    typedef enum logic [1:0] {
        CFG_ROM_LOG2   = 2'd0,
        CFG_PSRAM_LOG2 = 2'd1,
        CFG_PACK_LOG2  = 2'd2,
        CFG_RAM_LOG2   = 2'd3
    } t_cfg_idx;

    localparam int ADDR_W   = 24;
    localparam int MADDR_W  = 23;
    localparam int LOG2_W   = 5;
    localparam int NREGS    = 16;
    localparam int RIDX_W   = 4;

    // Mode bits set after reset: 2,3,5,6,7,8,9,11
    localparam logic [NREGS-1:0] ACT_RESET = 16'h0BEC;
    localparam logic [RIDX_W-1:0] REG_COMMIT = 4'he;

    localparam logic [LOG2_W-1:0] ROM_LOG2_RST   = 5'd20;
    localparam logic [LOG2_W-1:0] PSRAM_LOG2_RST = 5'd19;
    localparam logic [LOG2_W-1:0] PACK_LOG2_RST  = 5'd20;
    localparam logic [LOG2_W-1:0] RAM_LOG2_RST   = 5'd15;

    typedef struct packed {
        t_opcode           opcode;
        logic [ADDR_W-1:0] bus_addr;
        logic [7:0]        wdata;
    } t_req;

    typedef struct packed {
        t_target            target;
        logic [MADDR_W-1:0] mapped_addr;
        logic               is_write;
        logic [7:0]         read_data;
    } t_rsp;

    typedef struct packed {
        logic [LOG2_W-1:0] rom;
        logic [LOG2_W-1:0] psram;
        logic [LOG2_W-1:0] pack;
        logic [LOG2_W-1:0] ram;
    } t_cfg;

    typedef struct packed {
        logic              en;
        logic [RIDX_W-1:0] idx;
        logic [7:0]        data;
    } t_reg_wr;

    // Power-of-two mirror; sizes past the address width keep every bit.
    function automatic logic [MADDR_W-1:0] mirror(logic [MADDR_W-1:0] a,
                                                  logic [LOG2_W-1:0] lg);
        logic [MADDR_W-1:0] m;
        if (lg >= LOG2_W'(MADDR_W)) begin
            m = '1;
        end else begin
            m = (MADDR_W'(1) << lg) - MADDR_W'(1);
        end
        return a & m;
    endfunction

    function automatic logic hit(logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] mask,
                                 logic [ADDR_W-1:0] val);
        return (a & mask) == val;
    endfunction

endpackage

/* rtl/core/cbm_regfile.sv */
// Staged mode register file and the committed mode bits.
module cbm_regfile (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  cbm_pkg::t_reg_wr          i_wr,
    input  logic [cbm_pkg::RIDX_W-1:0] i_rd_idx,
    output logic [7:0]                o_rd_data,
    output logic [cbm_pkg::NREGS-1:0] o_active
);
    import cbm_pkg::*;

    logic [7:0]       r_regs [NREGS];
    logic [7:0]       n_regs [NREGS];
    logic [NREGS-1:0] r_act;
    logic [NREGS-1:0] n_act;
    logic             commit;

    // commit takes the value being written this cycle as well
    assign commit = i_wr.en && (i_wr.idx == REG_COMMIT) && i_wr.data[7];

    always_comb begin
        for (int i = 0; i < NREGS; i++) begin
            if (i_wr.en && (i_wr.idx == RIDX_W'(i))) begin
                n_regs[i] = i_wr.data;
            end else begin
                n_regs[i] = r_regs[i];
            end
            n_act[i] = commit ? n_regs[i][7] : r_act[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NREGS; i++) begin
                r_regs[i] <= {ACT_RESET[i], 7'd0};
            end
            r_act <= ACT_RESET;
        end else begin
            for (int i = 0; i < NREGS; i++) begin
                r_regs[i] <= n_regs[i];
            end
            r_act <= n_act;
        end
    end

    assign o_rd_data = r_regs[i_rd_idx];
    assign o_active  = r_act;

endmodule

/* rtl/core/cbm_decode.sv */
// Address decode: cartridge layout, register space and mirroring.
module cbm_decode (
    input  cbm_pkg::t_req             i_req,
    input  cbm_pkg::t_cfg             i_cfg,
    input  logic [cbm_pkg::NREGS-1:0] i_active,
    input  logic [7:0]                i_rd_data,
    output cbm_pkg::t_rsp             o_rsp,
    output cbm_pkg::t_reg_wr          o_wr
);
    import cbm_pkg::*;

    logic [ADDR_W-1:0]  a;
    logic [MADDR_W-1:0] lo_map;
    logic               hi, p3, p4, m5, m6;
    t_target            c_tgt;
    logic [MADDR_W-1:0] c_ma;
    t_target            tgt;
    logic [MADDR_W-1:0] ma;
    logic [7:0]         rd;
    logic               wr;
    logic               reg_hit;

    assign a      = i_req.bus_addr;
    assign lo_map = {1'b0, a[22:16], a[14:0]};
    assign hi     = i_active[2];
    assign p3     = i_active[3];
    assign p4     = i_active[4];
    assign m5     = i_active[5];
    assign m6     = i_active[6];

    // cartridge space, first match wins
    always_comb begin
        c_tgt = TGT_OPEN;
        c_ma  = '0;
        if ((hit(a, 24'he08000, 24'h008000) && i_active[7]) ||
            (hit(a, 24'he08000, 24'h808000) && i_active[8])) begin
            c_tgt = TGT_ROM;
            c_ma  = MADDR_W'({a[20:16], a[14:0]});
        end else if (!hi && ((hit(a, 24'hf28000, 24'h700000) && p3) ||
                             (hit(a, 24'hf08000, 24'hf00000) && p4))) begin
            c_tgt = TGT_PSRAM;
            c_ma  = MADDR_W'(a[18:0]);
        end else if (!hi && (
                (hit(a, 24'hf08000, 24'h008000) && p3 && !m5 && !m6) ||
                (hit(a, 24'hf08000, 24'h808000) && p4 && !m5 && !m6) ||
                (hit(a, 24'hf08000, 24'h208000) && p3 &&  m5 && !m6) ||
                (hit(a, 24'hf08000, 24'ha08000) && p4 &&  m5 && !m6) ||
                (hit(a, 24'hf00000, 24'h400000) && p3 && !m5 &&  m6) ||
                (hit(a, 24'hf00000, 24'hc00000) && p4 && !m5 &&  m6) ||
                (hit(a, 24'hf00000, 24'h600000) && p3 &&  m5 &&  m6) ||
                (hit(a, 24'hf00000, 24'he00000) && p4 &&  m5 &&  m6))) begin
            c_tgt = TGT_PSRAM;
            c_ma  = lo_map;
        end else if (hi && ((hit(a, 24'he0e000, 24'h206000) && p3) ||
                            (hit(a, 24'he0e000, 24'ha06000) && p4))) begin
            c_tgt = TGT_PSRAM;
            c_ma  = MADDR_W'({2'b11, a[12:0]});
        end else if (hi && (
                (hit(a, 24'hf80000, 24'h400000) && p3 && !m5 && !m6) ||
                (hit(a, 24'hf80000, 24'h500000) && p3 &&  m5 && !m6) ||
                (hit(a, 24'hf80000, 24'h600000) && p3 && !m5 &&  m6) ||
                (hit(a, 24'hf80000, 24'h700000) && p3 &&  m5 &&  m6) ||
                (hit(a, 24'hf80000, 24'hc00000) && p4 && !m5 && !m6) ||
                (hit(a, 24'hf80000, 24'hd00000) && p4 &&  m5 && !m6) ||
                (hit(a, 24'hf80000, 24'he00000) && p4 && !m5 &&  m6) ||
                (hit(a, 24'hf80000, 24'hf00000) && p4 &&  m5 &&  m6))) begin
            c_tgt = TGT_PSRAM;
            c_ma  = MADDR_W'(a[19:0]);
        end else if (!hi && (
                (hit(a, 24'he08000, 24'h008000) && i_active[9]  && !i_active[11]) ||
                (hit(a, 24'he00000, 24'h400000) && i_active[9]  &&  i_active[11]) ||
                (hit(a, 24'he08000, 24'h808000) && i_active[10] && !i_active[11]) ||
                (hit(a, 24'he00000, 24'hc00000) && i_active[10] &&  i_active[11]))) begin
            c_tgt = TGT_OPEN;  // memory-pack hole
        end else if (hi && (
                (hit(a, 24'hb08000, 24'h008000) && i_active[9]  && !i_active[11]) ||
                (hit(a, 24'hb08000, 24'h208000) && i_active[9]  &&  i_active[11]) ||
                (hit(a, 24'hb08000, 24'h808000) && i_active[10] && !i_active[11]) ||
                (hit(a, 24'hb08000, 24'ha08000) && i_active[10] &&  i_active[11]))) begin
            c_tgt = TGT_OPEN;
        end else if (hit(a, 24'h408000, 24'h008000) || a[22]) begin
            c_tgt = TGT_PACK;
            c_ma  = hi ? a[22:0] : lo_map;
        end
    end

    assign reg_hit = hit(a, 24'hf0ffff, 24'h005000);
    assign wr      = i_req.opcode[0];

    always_comb begin
        tgt = TGT_NONE;
        ma  = '0;
        rd  = '0;
        unique case (i_req.opcode)
            OP_CART_RD, OP_CART_WR: begin
                tgt = c_tgt;
                case (c_tgt)
                    TGT_ROM:   ma = mirror(c_ma, i_cfg.rom);
                    TGT_PSRAM: ma = mirror(c_ma, i_cfg.psram);
                    TGT_PACK:  ma = mirror(c_ma, i_cfg.pack);
                    default:   ma = c_ma;
                endcase
            end
            OP_REG_RD, OP_REG_WR: begin
                if (reg_hit) begin
                    tgt = TGT_REG;
                    ma  = MADDR_W'(a[19:16]);
                    rd  = wr ? 8'd0 : i_rd_data;
                end else if (hit(a, 24'hf8f000, 24'h105000)) begin
                    tgt = TGT_RAM;
                    ma  = mirror(MADDR_W'({a[18:16], a[11:0]}), i_cfg.ram);
                end
            end
            default: tgt = TGT_NONE;
        endcase
    end

    always_comb begin
        o_rsp.target      = tgt;
        o_rsp.mapped_addr = ma;
        o_rsp.is_write    = wr && (tgt != TGT_OPEN) && (tgt != TGT_NONE);
        o_rsp.read_data   = rd;
    end

    always_comb begin
        o_wr.en   = (i_req.opcode == OP_REG_WR) && reg_hit;
        o_wr.idx  = a[19:16];
        o_wr.data = i_req.wdata;
    end

endmodule

/* rtl/core/cartridge_bank_mapper_unit.sv */
// Top level of the cartridge bank mapper: request register, decode, result register.
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+----------------------------------
//  request   | in        | i_valid / o_ready  | i_req  (opcode, bus_addr, wdata)
//  result    | out       | o_valid / i_ready  | o_rsp  (target, mapped_addr, ...)
//  config    | in        | i_cfg_we           | i_cfg_idx, i_cfg_wdata
//
// One request per cycle sustained while i_ready is high; each request goes through the request
// register, then decode into the result register.
// Register writes update the staged file when their request leaves the request register,
// so a following request sees the new register contents and, after a commit, the new mode bits.
// Synchronous active-low reset clears the valid flags and loads the default mode bits and sizes.
// A stalled result holds both stages; o_ready stays high while the result register drains.
module cartridge_bank_mapper_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  cbm_pkg::t_req               i_req,
    output logic                        o_valid,
    input  logic                        i_ready,
    output cbm_pkg::t_rsp               o_rsp,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [cbm_pkg::LOG2_W-1:0]  i_cfg_wdata
);
    import cbm_pkg::*;

    t_cfg             r_cfg;
    t_req             r_req;
    logic             r_req_vld;
    t_rsp             r_rsp;
    logic             r_rsp_vld;
    logic             advance;
    t_rsp             dec_rsp;
    t_reg_wr          dec_wr;
    t_reg_wr          reg_wr;
    logic [7:0]       rd_data;
    logic [NREGS-1:0] active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rom   <= ROM_LOG2_RST;
            r_cfg.psram <= PSRAM_LOG2_RST;
            r_cfg.pack  <= PACK_LOG2_RST;
            r_cfg.ram   <= RAM_LOG2_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ROM_LOG2:   r_cfg.rom   <= i_cfg_wdata;
                CFG_PSRAM_LOG2: r_cfg.psram <= i_cfg_wdata;
                CFG_PACK_LOG2:  r_cfg.pack  <= i_cfg_wdata;
                CFG_RAM_LOG2:   r_cfg.ram   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // request moves on when the result register is free or being emptied
    assign advance = r_req_vld && (!r_rsp_vld || i_ready);
    assign o_ready = !r_req_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
            r_rsp_vld <= 1'b0;
        end else begin
            if (o_ready) begin
                r_req_vld <= i_valid;
            end
            if (advance) begin
                r_rsp_vld <= 1'b1;
            end else if (i_ready) begin
                r_rsp_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req <= i_req;
        end
        if (advance) begin
            r_rsp <= dec_rsp;
        end
    end

    always_comb begin
        reg_wr    = dec_wr;
        reg_wr.en = dec_wr.en && advance;
    end

    cbm_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (reg_wr),
        .i_rd_idx  (r_req.bus_addr[19:16]),
        .o_rd_data (rd_data),
        .o_active  (active)
    );

    cbm_decode u_decode (
        .i_req     (r_req),
        .i_cfg     (r_cfg),
        .i_active  (active),
        .i_rd_data (rd_data),
        .o_rsp     (dec_rsp),
        .o_wr      (dec_wr)
    );

    assign o_valid = r_rsp_vld;
    assign o_rsp   = r_rsp;

    a_open_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_rsp.target == TGT_OPEN || o_rsp.target == TGT_NONE)
            |-> (o_rsp.mapped_addr == '0) && !o_rsp.is_write)
        else $error("open bus or unmapped result carries an address or a write");

    a_rdata_reg_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_rsp.target != TGT_REG) |-> (o_rsp.read_data == 8'd0))
        else $error("read data outside register target");

    a_reg_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_rsp.target == TGT_REG) |-> (o_rsp.mapped_addr < MADDR_W'(NREGS)))
        else $error("register index out of range");

    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_vld && !i_ready |=> r_rsp_vld && $stable(r_rsp))
        else $error("stalled result lost or changed");

endmodule
